// ===== design/assert_macros.svh =====
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SCV_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define SCV_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== design/scv_pkg.sv =====
// Types and fixed constants of the vertical seam cost block.
package scv_pkg;

  localparam int IMG_WIDTH_BITS  = 12;
  localparam int IMG_HEIGHT_BITS = 16;
  localparam int ENERGY_BITS     = 16;
  localparam int CUM_COST_BITS   = 32;
  localparam int COUNT_BITS      = 27;
  localparam int CFG_INDEX_BITS  = 1;
  localparam int CFG_DATA_BITS   = 16;

  localparam logic [IMG_WIDTH_BITS-1:0]  WIDTH_RESET  = 12'd640;
  localparam logic [IMG_HEIGHT_BITS-1:0] HEIGHT_RESET = 16'd480;
  localparam logic [COUNT_BITS-1:0]      COUNT_MAX    = {COUNT_BITS{1'b1}};

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // Position of a pixel within its frame, decided at acceptance.
  typedef struct packed {
    logic row0;
    logic first;
    logic left;
    logic right;
    logic last;
  } pix_flags_t;

endpackage

// ===== design/scv_if.sv =====
// Valid/ready channel interfaces for the pixel input and the cost output.
interface scv_in_if import scv_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [ENERGY_BITS-1:0] energy;

  modport source (output valid, output energy, input ready);
  modport sink   (input valid, input energy, output ready);
endinterface

interface scv_out_if import scv_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CUM_COST_BITS-1:0] cum_cost;
  logic [COUNT_BITS-1:0]    nonzero_count;
  logic                     frame_last;

  modport source (output valid, output cum_cost, output nonzero_count, output frame_last,
                  input ready);
  modport sink   (input valid, input cum_cost, input nonzero_count, input frame_last,
                  output ready);
endinterface

// ===== design/scv_scan.sv =====
// Frame position tracking, configuration registers and the accept stage.
module scv_scan import scv_pkg::*; #(
  parameter int MAX_WIDTH = 2048,
  localparam int COL_BITS = $clog2(MAX_WIDTH)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  scv_in_if.sink                    pix_in,
  input  logic                      s1_fire,
  output logic                      s1_valid,
  output logic [ENERGY_BITS-1:0]    s1_energy,
  output logic [COL_BITS-1:0]       s1_col,
  output pix_flags_t                s1_flags,
  output logic                      rd_en,
  output logic [COL_BITS-1:0]       rd_addr0,
  output logic [COL_BITS-1:0]       rd_addr1
);

  localparam int WB = $clog2(MAX_WIDTH + 1);

  logic [IMG_WIDTH_BITS-1:0]  image_width;
  logic [IMG_HEIGHT_BITS-1:0] image_height;
  logic [WB-1:0]              eff_w;
  logic [IMG_HEIGHT_BITS-1:0] eff_h;

  logic [COL_BITS-1:0]        column_index;
  logic [IMG_HEIGHT_BITS-1:0] row_index;
  logic [COL_BITS-1:0]        column_index_next;
  logic [IMG_HEIGHT_BITS-1:0] row_index_next;

  logic                       wrap_col;
  logic [COL_BITS-1:0]        cur_col;
  logic [IMG_HEIGHT_BITS-1:0] row_pre;
  logic [IMG_HEIGHT_BITS-1:0] cur_row;
  logic                       col_is_last;
  logic                       row_is_last;
  pix_flags_t                 flags;
  logic                       accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data[IMG_WIDTH_BITS-1:0];
        CFG_IMAGE_HEIGHT: image_height <= cfg_data[IMG_HEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Clamp width to 2..MAX_WIDTH (the line buffer size), treat a zero height as one row
  always_comb begin
    if (image_width < 12'd2) begin
      eff_w = WB'(2);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      eff_w = WB'(MAX_WIDTH);
    end else begin
      eff_w = WB'(image_width);
    end
    eff_h = (image_height == '0) ? IMG_HEIGHT_BITS'(1) : image_height;
  end

  // A shrunk frame can leave the stored position outside it: wrap first
  always_comb begin
    wrap_col    = 32'(column_index) >= 32'(eff_w);
    cur_col     = wrap_col ? '0 : column_index;
    row_pre     = wrap_col ? row_index + IMG_HEIGHT_BITS'(1) : row_index;
    cur_row     = (row_pre >= eff_h) ? '0 : row_pre;
    col_is_last = (32'(cur_col) + 32'd1) == 32'(eff_w);
    row_is_last = (17'(cur_row) + 17'd1) == 17'(eff_h);

    flags.row0  = cur_row == '0;
    flags.left  = cur_col == '0;
    flags.first = flags.row0 && flags.left;
    flags.right = col_is_last;
    flags.last  = row_is_last && col_is_last;

    if (col_is_last) begin
      column_index_next = '0;
      row_index_next    = row_is_last ? '0 : cur_row + IMG_HEIGHT_BITS'(1);
    end else begin
      column_index_next = cur_col + COL_BITS'(1);
      row_index_next    = cur_row;
    end
  end

  assign pix_in.ready = !s1_valid || s1_fire;
  assign accept       = pix_in.valid && pix_in.ready;

  // Fetch the row above at this column and the next one
  assign rd_en    = accept;
  assign rd_addr0 = cur_col;
  assign rd_addr1 = cur_col + COL_BITS'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_index <= '0;
      row_index    <= '0;
      s1_valid     <= 1'b0;
    end else begin
      if (accept) begin
        column_index <= column_index_next;
        row_index    <= row_index_next;
        s1_valid     <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_energy <= pix_in.energy;
      s1_col    <= cur_col;
      s1_flags  <= flags;
    end
  end

endmodule

// ===== design/scv_line_buf.sv =====
// Line buffer of previous-row costs: one write port, two registered read ports.
module scv_line_buf #(
  parameter int MAX_WIDTH = 2048,
  parameter int COST_BITS = 32,
  localparam int COL_BITS = $clog2(MAX_WIDTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [COL_BITS-1:0]  waddr,
  input  logic [COST_BITS-1:0] wdata,
  input  logic                 re,
  input  logic [COL_BITS-1:0]  raddr0,
  input  logic [COL_BITS-1:0]  raddr1,
  output logic [COST_BITS-1:0] rdata0,
  output logic [COST_BITS-1:0] rdata1
);

  logic [COST_BITS-1:0] mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Forward a write to the same entry in the same cycle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata0 <= (we && (waddr == raddr0)) ? wdata : mem[raddr0];
      rdata1 <= (we && (waddr == raddr1)) ? wdata : mem[raddr1];
    end
  end

endmodule

// ===== design/scv_cost.sv =====
// Cost update, line buffer write-back, nonzero count and the output register.
module scv_cost import scv_pkg::*; #(
  parameter int MAX_WIDTH = 2048,
  parameter int COST_BITS = 32,
  localparam int COL_BITS = $clog2(MAX_WIDTH)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s1_valid,
  input  logic [ENERGY_BITS-1:0] s1_energy,
  input  logic [COL_BITS-1:0]    s1_col,
  input  pix_flags_t             s1_flags,
  input  logic [COST_BITS-1:0]   rd0,
  input  logic [COST_BITS-1:0]   rd1,
  output logic                   s1_fire,
  output logic                   we,
  output logic [COL_BITS-1:0]    waddr,
  output logic [COST_BITS-1:0]   wdata,
  scv_out_if.source              cost_out
);

  logic [COST_BITS-1:0]  above_left;
  logic [COUNT_BITS-1:0] nonzero_total;

  logic [COST_BITS-1:0]  min_lc;
  logic [COST_BITS-1:0]  min_cr;
  logic [COST_BITS-1:0]  min_above;
  logic [COST_BITS:0]    sum;
  logic [COST_BITS-1:0]  sat;
  logic [COST_BITS-1:0]  cost;
  logic [COUNT_BITS-1:0] count_base;
  logic [COUNT_BITS-1:0] count_next;

  assign s1_fire = s1_valid && (!cost_out.valid || cost_out.ready);

  always_comb begin
    min_lc = (above_left < rd0) ? above_left : rd0;
    min_cr = (rd0 < rd1) ? rd0 : rd1;
    if (s1_flags.left) begin
      min_above = min_cr;
    end else if (s1_flags.right) begin
      min_above = min_lc;
    end else begin
      min_above = (min_lc < rd1) ? min_lc : rd1;
    end

    // Row zero takes the energy as it is; other rows saturate, then take one off a positive sum
    sum = (COST_BITS + 1)'(s1_energy) + {1'b0, min_above};
    sat = sum[COST_BITS] ? {COST_BITS{1'b1}} : sum[COST_BITS-1:0];
    if (s1_flags.row0) begin
      cost = COST_BITS'(s1_energy);
    end else if (sat != '0) begin
      cost = sat - COST_BITS'(1);
    end else begin
      cost = '0;
    end

    count_base = s1_flags.first ? '0 : nonzero_total;
    if (!s1_flags.row0 && (cost != '0) && (count_base != COUNT_MAX)) begin
      count_next = count_base + COUNT_BITS'(1);
    end else begin
      count_next = count_base;
    end
  end

  assign we    = s1_fire;
  assign waddr = s1_col;
  assign wdata = cost;

  always_ff @(posedge clk) begin
    if (rst) begin
      above_left     <= '0;
      nonzero_total  <= '0;
      cost_out.valid <= 1'b0;
    end else begin
      if (s1_fire) begin
        // This column's old value is the next pixel's upper-left neighbour
        above_left     <= rd0;
        nonzero_total  <= count_next;
        cost_out.valid <= 1'b1;
      end else if (cost_out.ready) begin
        cost_out.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      cost_out.cum_cost      <= CUM_COST_BITS'(cost);
      cost_out.nonzero_count <= count_next;
      cost_out.frame_last    <= s1_flags.last;
    end
  end

endmodule

// ===== design/seam_cost_vertical_dp.sv =====
// Top level: streaming vertical seam cumulative cost over a raster of pixel energies.
//
// Pixel energies enter in raster order on pix_in and each one produces exactly one
// result on cost_out: its cumulative vertical seam cost, the running count of nonzero
// costs from row one onward in the current frame, and a flag on the frame's last pixel.
// The block takes one pixel every clock cycle unless cost_out stalls; the limit is the
// single line buffer, which gives two reads and one write per cycle. Pixels are held in
// s1 and results in the output register; a new pixel is taken into an empty s1 while a
// finished result waits on a stalled output. The line buffer holds MAX_WIDTH entries of
// COST_BITS bits and needs no clearing pass after reset; it is valid once one full row
// has gone through. Write image_width and image_height only while no transaction is in
// flight; widths are clamped to 2..MAX_WIDTH and a height of zero counts as one row.
module seam_cost_vertical_dp import scv_pkg::*; #(
  parameter int MAX_WIDTH = 2048,
  parameter int COST_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  scv_in_if.sink                    pix_in,
  scv_out_if.source                 cost_out
);

  localparam int COL_BITS = $clog2(MAX_WIDTH);

  logic                   s1_valid;
  logic [ENERGY_BITS-1:0] s1_energy;
  logic [COL_BITS-1:0]    s1_col;
  pix_flags_t             s1_flags;
  logic                   s1_fire;
  logic                   rd_en;
  logic [COL_BITS-1:0]    rd_addr0;
  logic [COL_BITS-1:0]    rd_addr1;
  logic [COST_BITS-1:0]   rd0;
  logic [COST_BITS-1:0]   rd1;
  logic                   we;
  logic [COL_BITS-1:0]    waddr;
  logic [COST_BITS-1:0]   wdata;

  scv_scan #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_in    (pix_in),
    .s1_fire   (s1_fire),
    .s1_valid  (s1_valid),
    .s1_energy (s1_energy),
    .s1_col    (s1_col),
    .s1_flags  (s1_flags),
    .rd_en     (rd_en),
    .rd_addr0  (rd_addr0),
    .rd_addr1  (rd_addr1)
  );

  scv_line_buf #(
    .MAX_WIDTH (MAX_WIDTH),
    .COST_BITS (COST_BITS)
  ) u_line_buf (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .re     (rd_en),
    .raddr0 (rd_addr0),
    .raddr1 (rd_addr1),
    .rdata0 (rd0),
    .rdata1 (rd1)
  );

  scv_cost #(
    .MAX_WIDTH (MAX_WIDTH),
    .COST_BITS (COST_BITS)
  ) u_cost (
    .clk       (clk),
    .rst       (rst),
    .s1_valid  (s1_valid),
    .s1_energy (s1_energy),
    .s1_col    (s1_col),
    .s1_flags  (s1_flags),
    .rd0       (rd0),
    .rd1       (rd1),
    .s1_fire   (s1_fire),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata),
    .cost_out  (cost_out)
  );

endmodule

// ===== design/scv_checker.sv =====
// Port-level checker for the vertical seam cost block, with its bind.
`include "assert_macros.svh"

module scv_checker import scv_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [CUM_COST_BITS-1:0] cum_cost,
  input logic [COUNT_BITS-1:0]    nonzero_count,
  input logic                     frame_last
);

  logic [2:0] outstanding;
  logic [2:0] outstanding_next;

  // Pixels accepted whose result has not yet been taken
  assign outstanding_next = outstanding + 3'(in_valid && in_ready) - 3'(out_valid && out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding_next;
    end
  end

  `SCV_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(cum_cost) && $stable(nonzero_count) && $stable(frame_last))
  `SCV_ASSERT_IMP(a_no_phantom, clk, rst, out_valid, outstanding != 3'd0)
  `SCV_ASSERT_IMP(a_depth, clk, rst, 1'b1, outstanding <= 3'd2)
  `SCV_ASSERT_IMP(a_empty_ready, clk, rst, outstanding == 3'd0, in_ready)

endmodule

bind seam_cost_vertical_dp scv_checker u_scv_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (pix_in.valid),
  .in_ready      (pix_in.ready),
  .out_valid     (cost_out.valid),
  .out_ready     (cost_out.ready),
  .cum_cost      (cost_out.cum_cost),
  .nonzero_count (cost_out.nonzero_count),
  .frame_last    (cost_out.frame_last)
);
